FILE: hw/rtl/htsd_pkg.sv
// ============================================================================
// htsd_pkg
// Shared types, constants and helpers for the HTML tag strip / entity decoder.
// ============================================================================
`default_nettype none

package htsd_pkg;

    // Whitespace hold depth and derived widths
    localparam int HOLD_DEPTH = 16;
    localparam int HOLD_IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int HOLD_SUM_W = HOLD_IDX_W + 2;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    // Character codes
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_QUOTE = 8'h22;  // '"'

    // Scan mode
    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_TAG    = 2'd1,
        MODE_ENTITY = 2'd2
    } mode_t;

    // Entity kinds
    typedef enum logic [2:0] {
        ENT_NONE,
        ENT_LT,
        ENT_GT,
        ENT_AMP,
        ENT_QUOT
    } ent_kind_t;

    // Token source for the emit path
    typedef enum logic [1:0] {
        TOK_AMP,
        TOK_LETTER,
        TOK_BYTE,
        TOK_DEC
    } tok_sel_t;

    // Result byte source
    typedef enum logic {
        SRC_HOLD,
        SRC_TOK
    } res_src_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_HANDLE,
        S_EMIT,
        S_FLUSH_NEXT,
        S_TAIL,
        S_FIN
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     latch_in;
        logic     mode_we;
        mode_t    mode_val;
        logic     let_we;
        logic     prog_clr;
        logic     tok_ld;
        tok_sel_t tok_sel;
        logic     idx_clr;
        logic     idx_inc;
        logic     sp_push;
        logic     sp_pop;
        logic     res_put;
        res_src_t res_src;
        logic     fin;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  eol;
        logic  b_lt;
        logic  b_gt;
        logic  b_amp;
        logic  ent_consume;
        logic  ent_decode;
        logic  tok_ws;
        logic  sp_empty;
        logic  sp_full;
        logic  idx_lt_prog;
        logic  out_ok;
        logic  fin_ok;
    } dp_stat_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'd32) : b;
    endfunction

    function automatic ent_kind_t ent_classify(input logic [7:0] c);
        ent_kind_t k;
        unique case (c)
            8'h6C:   k = ENT_LT;    // 'l'
            8'h67:   k = ENT_GT;    // 'g'
            8'h61:   k = ENT_AMP;   // 'a'
            8'h71:   k = ENT_QUOT;  // 'q'
            default: k = ENT_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] ent_len(input ent_kind_t k);
        logic [2:0] n;
        unique case (k)
            ENT_LT, ENT_GT: n = 3'd2;
            ENT_AMP:        n = 3'd3;
            ENT_QUOT:       n = 3'd4;
            default:        n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] ent_dec(input ent_kind_t k);
        logic [7:0] d;
        unique case (k)
            ENT_LT:   d = CH_LT;
            ENT_GT:   d = CH_GT;
            ENT_AMP:  d = CH_AMP;
            ENT_QUOT: d = CH_QUOTE;
            default:  d = 8'h00;
        endcase
        return d;
    endfunction

    // Lowercase letter expected at a position of the entity name
    function automatic logic [7:0] ent_char(input ent_kind_t k, input logic [1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (k)
            ENT_LT:   c = (pos == 2'd0) ? 8'h6C : 8'h74;                 // l t
            ENT_GT:   c = (pos == 2'd0) ? 8'h67 : 8'h74;                 // g t
            ENT_AMP: begin
                unique case (pos)
                    2'd0:    c = 8'h61;                                  // a
                    2'd1:    c = 8'h6D;                                  // m
                    default: c = 8'h70;                                  // p
                endcase
            end
            ENT_QUOT: begin
                unique case (pos)
                    2'd0:    c = 8'h71;                                  // q
                    2'd1:    c = 8'h75;                                  // u
                    2'd2:    c = 8'h6F;                                  // o
                    default: c = 8'h74;                                  // t
                endcase
            end
            default:  c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/htsd_ctrl.sv
// ============================================================================
// htsd_ctrl
// Sequencer: walks one input byte through tag, entity and emit steps.
// ============================================================================
`default_nettype none

module htsd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire htsd_pkg::dp_stat_t stat,
    output htsd_pkg::dp_cmd_t      cmd
);
    import htsd_pkg::*;

    state_t state_reg, state_next;
    logic   ret_flush_reg, ret_flush_next;   // emit returns into the flush loop
    logic   flush_eol_reg, flush_eol_next;   // flush was started by line end
    logic   emit_done;

    // Emit step completes: whitespace is parked, non-space goes out after held spaces
    always_comb begin
        if (stat.tok_ws) begin
            emit_done = !stat.sp_full || stat.out_ok;
        end else begin
            emit_done = stat.sp_empty && stat.out_ok;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ret_flush_reg <= 1'b0;
            flush_eol_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_flush_reg <= ret_flush_next;
            flush_eol_reg <= flush_eol_next;
        end
    end

    // Next state
    always_comb begin
        state_next     = state_reg;
        ret_flush_next = ret_flush_reg;
        flush_eol_next = flush_eol_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_EVAL;
            end
            S_EVAL: begin
                unique case (stat.mode)
                    MODE_TAG: state_next = S_TAIL;
                    MODE_ENTITY: begin
                        if (stat.ent_consume) begin
                            state_next = S_TAIL;
                        end else if (stat.ent_decode) begin
                            state_next     = S_EMIT;
                            ret_flush_next = 1'b0;
                        end else begin
                            state_next     = S_EMIT;
                            ret_flush_next = 1'b1;
                            flush_eol_next = 1'b0;
                        end
                    end
                    default: state_next = S_HANDLE;
                endcase
            end
            S_HANDLE: begin
                if (stat.b_lt || stat.b_amp) begin
                    state_next = S_TAIL;
                end else begin
                    state_next     = S_EMIT;
                    ret_flush_next = 1'b0;
                end
            end
            S_EMIT: begin
                if (emit_done) state_next = ret_flush_reg ? S_FLUSH_NEXT : S_TAIL;
            end
            S_FLUSH_NEXT: begin
                if (stat.idx_lt_prog) begin
                    state_next     = S_EMIT;
                    ret_flush_next = 1'b1;
                end else begin
                    state_next = flush_eol_reg ? S_FIN : S_HANDLE;
                end
            end
            S_TAIL: begin
                if (stat.eol && (stat.mode == MODE_ENTITY)) begin
                    state_next     = S_EMIT;
                    ret_flush_next = 1'b1;
                    flush_eol_next = 1'b1;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (stat.fin_ok) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // no transfer is taken while reset is held
                s_tready     = aresetn;
                cmd.latch_in = s_tvalid && aresetn;
            end
            S_EVAL: begin
                unique case (stat.mode)
                    MODE_TAG: begin
                        if (stat.b_gt) begin
                            cmd.mode_we  = 1'b1;
                            cmd.mode_val = MODE_TEXT;
                        end
                    end
                    MODE_ENTITY: begin
                        if (stat.ent_consume) begin
                            cmd.let_we = 1'b1;
                        end else if (stat.ent_decode) begin
                            cmd.tok_ld   = 1'b1;
                            cmd.tok_sel  = TOK_DEC;
                            cmd.prog_clr = 1'b1;
                            cmd.mode_we  = 1'b1;
                            cmd.mode_val = MODE_TEXT;
                        end else begin
                            cmd.tok_ld  = 1'b1;
                            cmd.tok_sel = TOK_AMP;
                            cmd.idx_clr = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_HANDLE: begin
                if (stat.b_lt) begin
                    cmd.mode_we  = 1'b1;
                    cmd.mode_val = MODE_TAG;
                end else if (stat.b_amp) begin
                    cmd.mode_we  = 1'b1;
                    cmd.mode_val = MODE_ENTITY;
                    cmd.prog_clr = 1'b1;
                end else begin
                    cmd.tok_ld  = 1'b1;
                    cmd.tok_sel = TOK_BYTE;
                end
            end
            S_EMIT: begin
                if (stat.tok_ws) begin
                    // full hold: oldest space goes out as the new one goes in
                    if (!stat.sp_full) begin
                        cmd.sp_push = 1'b1;
                    end else if (stat.out_ok) begin
                        cmd.sp_push = 1'b1;
                        cmd.sp_pop  = 1'b1;
                        cmd.res_put = 1'b1;
                        cmd.res_src = SRC_HOLD;
                    end
                end else if (stat.out_ok) begin
                    cmd.res_put = 1'b1;
                    if (!stat.sp_empty) begin
                        cmd.sp_pop  = 1'b1;
                        cmd.res_src = SRC_HOLD;
                    end else begin
                        cmd.res_src = SRC_TOK;
                    end
                end
            end
            S_FLUSH_NEXT: begin
                if (stat.idx_lt_prog) begin
                    cmd.tok_ld  = 1'b1;
                    cmd.tok_sel = TOK_LETTER;
                    cmd.idx_inc = 1'b1;
                end else begin
                    cmd.prog_clr = 1'b1;
                    cmd.mode_we  = 1'b1;
                    cmd.mode_val = MODE_TEXT;
                end
            end
            S_TAIL: begin
                if (stat.eol && (stat.mode == MODE_ENTITY)) begin
                    cmd.tok_ld  = 1'b1;
                    cmd.tok_sel = TOK_AMP;
                    cmd.idx_clr = 1'b1;
                end
            end
            S_FIN: begin
                cmd.fin = stat.fin_ok;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/htsd_dp.sv
// ============================================================================
// htsd_dp
// Datapath: input latch, entity matcher, whitespace hold and output stage.
// ============================================================================
`default_nettype none

module htsd_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [7:0]                      in_byte,
    input  wire logic                            in_line_end,
    input  wire htsd_pkg::dp_cmd_t               cmd,
    output htsd_pkg::dp_stat_t                   stat,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [7:0]                           out_byte,
    output logic                                 out_has_byte,
    output logic                                 out_line_done,
    output logic                                 out_last_of_run
);
    import htsd_pkg::*;

    // Input and scan state
    logic [7:0] b_reg;
    logic       eol_reg;
    mode_t      mode_reg;
    logic [2:0] prog_reg;
    logic [7:0] letters_reg [4];
    logic [2:0] idx_reg;
    logic [7:0] tok_reg;
    logic [7:0] tok_next;

    // Whitespace hold (circular)
    logic [7:0]            hold_reg [HOLD_DEPTH];
    logic [HOLD_IDX_W-1:0] rd_reg;
    logic [HOLD_IDX_W-1:0] rd_inc;
    logic [HOLD_IDX_W-1:0] wr_idx;
    logic [HOLD_SUM_W-1:0] wr_sum;
    logic [HOLD_CNT_W-1:0] cnt_reg;

    // Pending result and output register
    logic       pend_valid_reg;
    logic [7:0] pend_byte_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_has_reg;
    logic       out_done_reg;
    logic       out_last_reg;
    logic       out_free;
    logic       out_load;
    logic [7:0] out_byte_next;
    logic       out_has_next;
    logic       out_done_next;
    logic       out_last_next;

    // Entity matcher
    logic [7:0] lb;
    logic [7:0] first;
    ent_kind_t  kind;
    logic [2:0] elen;
    logic       ent_consume;
    logic       ent_decode;

    always_comb begin
        lb    = to_lower(b_reg);
        first = (prog_reg == 3'd0) ? lb : to_lower(letters_reg[0]);
        kind  = ent_classify(first);
        elen  = ent_len(kind);
        ent_consume = 1'b0;
        ent_decode  = 1'b0;
        if (kind != ENT_NONE) begin
            if (prog_reg < elen) begin
                ent_consume = (lb == ent_char(kind, prog_reg[1:0]));
            end else begin
                ent_decode = (b_reg == CH_SEMI);
            end
        end
    end

    // Hold pointers
    always_comb begin
        rd_inc = (rd_reg == HOLD_IDX_W'(HOLD_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        wr_sum = HOLD_SUM_W'(rd_reg) + HOLD_SUM_W'(cnt_reg);
        if (wr_sum >= HOLD_SUM_W'(HOLD_DEPTH)) begin
            wr_sum = wr_sum - HOLD_SUM_W'(HOLD_DEPTH);
        end
        wr_idx = wr_sum[HOLD_IDX_W-1:0];
    end

    // Token mux
    always_comb begin
        unique case (cmd.tok_sel)
            TOK_AMP:    tok_next = CH_AMP;
            TOK_LETTER: tok_next = letters_reg[idx_reg[1:0]];
            TOK_BYTE:   tok_next = b_reg;
            TOK_DEC:    tok_next = ent_dec(kind);
            default:    tok_next = b_reg;
        endcase
    end

    // Status to controller
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        stat.mode        = mode_reg;
        stat.eol         = eol_reg;
        stat.b_lt        = (b_reg == CH_LT);
        stat.b_gt        = (b_reg == CH_GT);
        stat.b_amp       = (b_reg == CH_AMP);
        stat.ent_consume = ent_consume;
        stat.ent_decode  = ent_decode;
        stat.tok_ws      = is_ws(tok_reg);
        stat.sp_empty    = (cnt_reg == '0);
        stat.sp_full     = (cnt_reg == HOLD_CNT_W'(HOLD_DEPTH));
        stat.idx_lt_prog = (idx_reg < prog_reg);
        stat.out_ok      = !pend_valid_reg || out_free;
        stat.fin_ok      = out_free || (!pend_valid_reg && !eol_reg);
    end

    // Output register load: previous pending moves out, or the run is closed
    always_comb begin
        out_load      = 1'b0;
        out_byte_next = pend_byte_reg;
        out_has_next  = 1'b1;
        out_done_next = 1'b0;
        out_last_next = 1'b0;
        if (cmd.res_put && pend_valid_reg) begin
            out_load = 1'b1;
        end else if (cmd.fin) begin
            if (pend_valid_reg) begin
                out_load      = 1'b1;
                out_done_next = eol_reg;
                out_last_next = 1'b1;
            end else if (eol_reg) begin
                // bare end marker
                out_load      = 1'b1;
                out_byte_next = 8'h00;
                out_has_next  = 1'b0;
                out_done_next = 1'b1;
                out_last_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_TEXT;
            prog_reg       <= '0;
            idx_reg        <= '0;
            rd_reg         <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.fin && eol_reg) begin
                mode_reg <= MODE_TEXT;
            end else if (cmd.mode_we) begin
                mode_reg <= cmd.mode_val;
            end

            if ((cmd.fin && eol_reg) || cmd.prog_clr) begin
                prog_reg <= '0;
            end else if (cmd.let_we) begin
                prog_reg <= prog_reg + 3'd1;
            end

            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 3'd1;
            end

            if (cmd.sp_pop) rd_reg <= rd_inc;

            // held spaces are dropped at line end
            if (cmd.fin && eol_reg) begin
                cnt_reg <= '0;
            end else if (cmd.sp_push && !cmd.sp_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (cmd.sp_pop && !cmd.sp_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            if (cmd.res_put) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.fin) begin
                pend_valid_reg <= 1'b0;
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers; the hold is read at the oldest entry on a pop
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            b_reg   <= in_byte;
            eol_reg <= in_line_end;
        end
        if (cmd.let_we) letters_reg[prog_reg[1:0]] <= b_reg;
        if (cmd.tok_ld) tok_reg <= tok_next;
        if (cmd.sp_push) hold_reg[wr_idx] <= tok_reg;
        if (cmd.res_put) begin
            pend_byte_reg <= (cmd.res_src == SRC_HOLD) ? hold_reg[rd_reg] : tok_reg;
        end
        if (out_load) begin
            out_byte_reg <= out_byte_next;
            out_has_reg  <= out_has_next;
            out_done_reg <= out_done_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign out_has_byte    = out_has_reg;
    assign out_line_done   = out_done_reg;
    assign out_last_of_run = out_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/html_tag_strip_entity_decode.sv
// ============================================================================
// html_tag_strip_entity_decode
// Line-oriented HTML cleaner: drops tags, decodes four entities, trims
// trailing whitespace and closes every line with an end marker.
// ============================================================================
// Usage:
//   s_ channel: one text byte per transfer in s_tdata[7:0], s_tlast on the
//   last byte of a line. m_ channel: one cleaned byte or end marker per
//   transfer. Every input byte yields zero or more results; the final result
//   caused by a byte has m_tdata[8] set, m_tlast marks the line's closing
//   result and m_tuser is low on a bare end marker.
//   Steps of a byte: a byte taken inside a tag or an entity goes through
//   accept, evaluate, tail and finish; a text byte adds a handle step, and
//   each emit step (one result or one parked space) adds one more. A broken
//   entity emits its '&', then each held letter through a flush step and an
//   emit step. The last result of a byte waits in a pending register and
//   reaches the output register in the finish cycle.
//   Reset (aresetn low, synchronous) returns to normal text with empty
//   holds. If the receiver stalls, the output register holds its transfer
//   and the sequencer waits; s_tready stays low until the byte is done.
// ============================================================================
`default_nettype none

module html_tag_strip_entity_decode (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [htsd_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] in_byte
    input  wire logic                              s_tlast,   // line_end
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] out_byte, [8] last_of_run, [15:9] zero
    output logic [htsd_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tuser,   // has_byte
    output logic                                   m_tlast    // line_done
);
    import htsd_pkg::*;

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       out_line_done;
    logic       out_last_of_run;

    htsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    htsd_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_byte         (s_tdata),
        .in_line_end     (s_tlast),
        .cmd             (cmd),
        .stat            (stat),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_byte        (out_byte),
        .out_has_byte    (out_has_byte),
        .out_line_done   (out_line_done),
        .out_last_of_run (out_last_of_run)
    );

    // Pack result fields
    assign m_tdata = {7'd0, out_last_of_run, out_byte};
    assign m_tuser = out_has_byte;
    assign m_tlast = out_line_done;

endmodule

`default_nettype wire

FILE: tb/html_tag_strip_entity_decode_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// html_tag_strip_entity_decode_checker
// Watches both stream channels of the HTML cleaner. Every accepted input byte
// is run through a local model of the cleaner (tag drop, entity decode,
// whitespace hold, line close). The cleaned results it predicts are queued
// and compared field by field with each result transfer, in order.
// ============================================================================

module html_tag_strip_entity_decode_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] in_byte
    input  logic                           s_tlast,   // line_end
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] out_byte, [8] last_of_run, [15:9] zero
    input  logic [htsd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tuser,   // has_byte
    input  logic                           m_tlast,   // line_done
    output int                             fail_count,
    output int                             awaiting
);
    import htsd_pkg::*;

    localparam int MAX_RESULTS_PER_BYTE = 22;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       line_done;
        logic       last_of_run;
    } clean_res_t;

    clean_res_t cleaned_q[$];     // predicted results not yet seen
    clean_res_t byte_results[$];  // results of the byte being modeled

    // Model state
    mode_t      scan_mode;
    int         ent_held;
    logic [7:0] ent_letters[4];
    logic [7:0] ws_hold[HOLD_DEPTH];
    int         ws_count;
    int         errors = 0;
    int         result_num = 0;

    function automatic bit is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [7:0] lower_case(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'h20 : b;
    endfunction

    task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
        $display("ERROR result %0d: %s expected %0h got %0h", result_num, what, want, got);
        errors++;
    endtask

    task automatic put_result(input logic [7:0] b, input logic has, input logic done);
        clean_res_t r;
        r.out_byte    = b;
        r.has_byte    = has;
        r.line_done   = done;
        r.last_of_run = 1'b0;
        if (byte_results.size() < MAX_RESULTS_PER_BYTE)
            byte_results.push_back(r);
    endtask

    // Whitespace is held until a non-space byte releases it
    task automatic hold_or_send(input logic [7:0] b);
        if (is_space(b)) begin
            if (ws_count >= HOLD_DEPTH) begin
                put_result(ws_hold[0], 1'b1, 1'b0);
                for (int i = 1; i < HOLD_DEPTH; i++)
                    ws_hold[i-1] = ws_hold[i];
                ws_count = HOLD_DEPTH - 1;
            end
            ws_hold[ws_count] = b;
            ws_count++;
        end else begin
            for (int i = 0; i < ws_count; i++)
                put_result(ws_hold[i], 1'b1, 1'b0);
            ws_count = 0;
            put_result(b, 1'b1, 1'b0);
        end
    endtask

    // Open entity fails: '&' and held letters go out as text
    task automatic dump_entity();
        hold_or_send(CH_AMP);
        for (int i = 0; i < ent_held && i < 4; i++)
            hold_or_send(ent_letters[i]);
        ent_held  = 0;
        scan_mode = MODE_TEXT;
    endtask

    task automatic plain_text(input logic [7:0] b);
        if (b == CH_LT) begin
            scan_mode = MODE_TAG;
        end else if (b == CH_AMP) begin
            scan_mode = MODE_ENTITY;
            ent_held  = 0;
        end else begin
            hold_or_send(b);
        end
    endtask

    task automatic entity_next(input logic [7:0] b, output bit taken);
        logic [7:0] lb;
        logic [7:0] first;
        logic [7:0] decoded;
        string      name;
        lb    = lower_case(b);
        first = (ent_held == 0) ? lb : lower_case(ent_letters[0]);
        taken = 1'b0;
        case (first)
            "l": begin name = "lt";   decoded = CH_LT;    end
            "g": begin name = "gt";   decoded = CH_GT;    end
            "a": begin name = "amp";  decoded = CH_AMP;   end
            "q": begin name = "quot"; decoded = CH_QUOTE; end
            default: return;
        endcase
        if (ent_held < name.len()) begin
            if (lb == name[ent_held]) begin
                ent_letters[ent_held] = b;
                ent_held++;
                taken = 1'b1;
            end
        end else if (b == CH_SEMI) begin
            ent_held  = 0;
            scan_mode = MODE_TEXT;
            hold_or_send(decoded);
            taken = 1'b1;
        end
    endtask

    // Model one accepted input byte and queue what it should produce
    task automatic clean_byte(input logic [7:0] b, input logic eol);
        bit taken;
        byte_results.delete();
        case (scan_mode)
            MODE_TAG: begin
                if (b == CH_GT)
                    scan_mode = MODE_TEXT;
            end
            MODE_ENTITY: begin
                entity_next(b, taken);
                if (!taken) begin
                    dump_entity();
                    plain_text(b);
                end
            end
            default: begin
                scan_mode = MODE_TEXT;
                plain_text(b);
            end
        endcase
        if (eol) begin
            if (scan_mode == MODE_ENTITY)
                dump_entity();
            scan_mode = MODE_TEXT;
            ent_held  = 0;
            ws_count  = 0;
            if (byte_results.size() > 0)
                byte_results[byte_results.size()-1].line_done = 1'b1;
            else
                put_result(8'h00, 1'b0, 1'b1);
        end
        if (byte_results.size() > 0)
            byte_results[byte_results.size()-1].last_of_run = 1'b1;
        foreach (byte_results[i])
            cleaned_q.push_back(byte_results[i]);
    endtask

    task automatic check_result();
        clean_res_t want;
        result_num++;
        if (cleaned_q.size() == 0) begin
            report("result with nothing expected, tdata", 16'h0, m_tdata);
        end else begin
            want = cleaned_q.pop_front();
            if (m_tdata[7:0] !== want.out_byte)
                report("out_byte", want.out_byte, m_tdata[7:0]);
            if (m_tdata[8] !== want.last_of_run)
                report("last_of_run", want.last_of_run, m_tdata[8]);
            if (m_tdata[15:9] !== 7'd0)
                report("tdata padding", 16'h0, m_tdata[15:9]);
            if (m_tuser !== want.has_byte)
                report("has_byte", want.has_byte, m_tuser);
            if (m_tlast !== want.line_done)
                report("line_done", want.line_done, m_tlast);
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode = MODE_TEXT;
            ent_held  = 0;
            ws_count  = 0;
            cleaned_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                clean_byte(s_tdata, s_tlast);
            if (m_tvalid === 1'b1 && m_tready)
                check_result();
        end
        awaiting   <= cleaned_q.size();
        fail_count <= errors;
    end

endmodule

FILE: tb/html_tag_strip_entity_decode_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// html_tag_strip_entity_decode_tb
// Drives text lines into the HTML cleaner: a short directed pass over tags,
// entities, mismatches and whitespace, then random lines built mostly from
// well-formed tags, entities and whitespace runs. Both sides insert random
// gaps; the checker predicts and compares every result transfer.
// ============================================================================

module html_tag_strip_entity_decode_tb;
    import htsd_pkg::*;

    localparam int RANDOM_ITEMS = 140;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] in_byte
    logic                 s_tlast;   // line_end
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [7:0] out_byte, [8] last_of_run, [15:9] zero
    logic                 m_tuser;   // has_byte
    logic                 m_tlast;   // line_done

    int    fail_count;
    int    awaiting;
    int    cycle_count = 0;
    int    items_sent;
    bit    no_gaps;
    string ent_names[4] = '{"lt", "gt", "amp", "quot"};

    html_tag_strip_entity_decode DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    html_tag_strip_entity_decode_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .awaiting   (awaiting)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("html_tag_strip_entity_decode verification failed");
            $finish;
        end
    end

    // Idle cycles before a transfer; stretches with no idling at all
    function automatic int pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic pick_eol();
        return $urandom_range(0, 15) == 0;
    endfunction

    // Tab, LF, VT, FF, CR or space
    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] random_case(input logic [7:0] c);
        return $urandom_range(0, 1) ? c - 8'h20 : c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic eol);
        int gap;
        gap = pick_gap();
        if ($urandom_range(0, 29) == 0)
            no_gaps = !no_gaps;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_str(input string s, input logic eol);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eol && (i == s.len() - 1));
    endtask

    // One random token: entity, broken entity, tag, whitespace run or text
    task automatic send_token();
        int    kind;
        int    n;
        string name;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: send_byte(8'($urandom_range(0, 255)), pick_eol());
            2, 3, 4: begin
                name = ent_names[$urandom_range(0, 3)];
                send_byte(CH_AMP, pick_eol());
                for (int i = 0; i < name.len(); i++)
                    send_byte(random_case(name[i]), pick_eol());
                send_byte(CH_SEMI, pick_eol());
            end
            5: begin
                name = ent_names[$urandom_range(0, 3)];
                n = $urandom_range(0, name.len());
                send_byte(CH_AMP, pick_eol());
                for (int i = 0; i < n; i++)
                    send_byte(random_case(name[i]), pick_eol());
                send_byte(8'($urandom_range(0, 255)), pick_eol());
            end
            6: begin
                send_byte(CH_LT, pick_eol());
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_GT)
                        c = "x";
                    send_byte(c, pick_eol());
                end
                if ($urandom_range(0, 4) != 0)
                    send_byte(CH_GT, pick_eol());
            end
            7, 8: begin
                // occasionally long enough to overflow the hold
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 20)
                                                : $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    send_byte(pick_space(), pick_eol());
                if ($urandom_range(0, 2) != 0)
                    send_byte(8'($urandom_range("a", "z")), pick_eol());
            end
            default: send_byte(8'($urandom_range("A", "z")), pick_eol());
        endcase
    endtask

    // Result side: random stall before each transfer
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Stimulus and verdict
    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        items_sent  = 0;
        no_gaps     = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: entity with mixed case, closed tag, zero byte
        send_str("&Lt;<p>", 1'b0);
        send_byte(8'h00, 1'b0);
        // amp, mismatch, whitespace released, trailing space cut at line end
        send_str("&amp;&ax \tz ", 1'b1);
        // entity still open at line end
        send_str("&Qu", 1'b1);
        // unclosed tag swallows the rest of the line
        send_str("<a", 1'b1);

        while (items_sent < 25 + RANDOM_ITEMS)
            send_token();
        // close the last line
        send_byte(CH_CR, 1'b1);
        s_tvalid <= 1'b0;

        while (awaiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("html_tag_strip_entity_decode verification clean");
        else
            $display("html_tag_strip_entity_decode verification failed");
        $finish;
    end

endmodule

FILE: html_tag_strip_entity_decode.f
hw/rtl/htsd_pkg.sv
hw/rtl/htsd_ctrl.sv
hw/rtl/htsd_dp.sv
hw/rtl/html_tag_strip_entity_decode.sv
tb/html_tag_strip_entity_decode_checker.sv
tb/html_tag_strip_entity_decode_tb.sv
